### design/asid_pkg.sv
// Shared constants, types and the mux code table for the ADC scan/average block.
// Used by asid_ctrl, asid_dp and adc_scan_integrate_decimate.
package asid_pkg;

  // Scan and averaging configuration
  localparam int NUM_CHANNELS  = 8;
  localparam int OVERSAMPLE    = 16;   // power of two
  localparam int SAMPLE_BITS   = 12;
  localparam int TOTAL_SAMPLES = OVERSAMPLE * NUM_CHANNELS;

  // Field widths fixed by the interface
  localparam int OP_W     = 2;
  localparam int SMP_W    = 12;
  localparam int CHAN_W   = 3;
  localparam int AVG_W    = 12;
  localparam int MUX_W    = 4;
  localparam int SUM_W    = 16;

  // Derived widths
  localparam int CH_W  = $clog2(NUM_CHANNELS);
  localparam int SL_W  = $clog2(TOTAL_SAMPLES + 1);
  localparam int OS_SH = $clog2(OVERSAMPLE);

  // Request op codes
  localparam logic [OP_W-1:0] OP_CONV    = 2'd0;
  localparam logic [OP_W-1:0] OP_CONSUME = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

  // Result kinds
  localparam logic KIND_CTRL = 1'b0;
  localparam logic KIND_AVG  = 1'b1;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_AVG  = 2'b10
  } state_t;

  // Which control result to build
  typedef enum logic [1:0] {
    CTRL_SAMPLE = 2'd0,
    CTRL_HELD   = 2'd1,
    CTRL_TICK   = 2'd2
  } ctrl_mode_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       acc_en;     // add sample, advance channel and count
    logic       ctrl_load;  // load a control result into the output register
    ctrl_mode_t ctrl_mode;
    logic       avg_load;   // load next average, clear its accumulator
    logic       hold_clr;   // averages consumed
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hold;       // averages held, samples dropped
    logic frame_end;  // the next accepted sample completes the frame
    logic avg_last;   // sweep is at the final channel
  } dp_stat_t;

  // Analog mux code of each scan position
  function automatic logic [MUX_W-1:0] mux_code(input logic [CHAN_W-1:0] ch);
    logic [MUX_W-1:0] code;
    unique case (ch)
      3'd0:    code = 4'h0;
      3'd1:    code = 4'h1;
      3'd2:    code = 4'h2;
      3'd3:    code = 4'h8;
      3'd4:    code = 4'h3;
      3'd5:    code = 4'h4;
      3'd6:    code = 4'h5;
      3'd7:    code = 4'h6;
      default: code = 4'h0;
    endcase
    return code;
  endfunction

endpackage

### design/asid_ctrl.sv
// Controller FSM: handshakes both channels and sequences the average sweep.
// Depends on asid_pkg; drives asid_dp through dp_cmd_t, reads dp_stat_t.
module asid_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [asid_pkg::OP_W-1:0]    in_op,
  output logic                         out_valid,
  input  logic                         out_ready,
  output asid_pkg::dp_cmd_t            cmd,
  input  asid_pkg::dp_stat_t           stat
);
  import asid_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   in_acc;

  // Output register is free when empty or being emptied this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.ctrl_mode  = CTRL_SAMPLE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_CONV) begin
            cmd.ctrl_load = 1'b1;
            if (stat.hold) begin
              cmd.ctrl_mode = CTRL_HELD;
            end else begin
              cmd.acc_en = 1'b1;
              if (stat.frame_end) state_nxt = ST_AVG;
            end
          end else if (in_op == OP_CONSUME) begin
            cmd.hold_clr = 1'b1;
          end else if (in_op == OP_TICK) begin
            cmd.ctrl_load = 1'b1;
            cmd.ctrl_mode = CTRL_TICK;
          end
        end
      end
      ST_AVG: begin
        if (slot_free) begin
          cmd.avg_load = 1'b1;
          if (stat.avg_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid tracking
  always_comb begin
    if (cmd.ctrl_load || cmd.avg_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/asid_dp.sv
// Datapath: scan position, sample count, accumulators, hold flag and result register.
// Depends on asid_pkg; commanded by asid_ctrl.
module asid_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [asid_pkg::SMP_W-1:0]    in_sample,
  input  asid_pkg::dp_cmd_t             cmd,
  output asid_pkg::dp_stat_t            stat,
  output logic                          out_kind,
  output logic [asid_pkg::CHAN_W-1:0]   out_channel,
  output logic [asid_pkg::AVG_W-1:0]    out_average,
  output logic [asid_pkg::MUX_W-1:0]    out_mux_select,
  output logic                          out_start_conversion,
  output logic                          out_accepted,
  output logic                          out_last
);
  import asid_pkg::*;

  logic [CH_W-1:0]  scan_r, scan_nxt;
  logic [CH_W-1:0]  idx_r, idx_nxt;
  logic [SL_W-1:0]  sl_r, sl_nxt;
  logic             hold_r, hold_nxt;
  logic [SUM_W-1:0] sums_r [NUM_CHANNELS];

  logic [CH_W-1:0]  scan_inc;
  logic [CH_W-1:0]  rd_addr;
  logic [SUM_W-1:0] rd_sum;
  logic [SUM_W-1:0] add_sum;

  // Result register
  logic              kind_r;
  logic [CHAN_W-1:0] chan_r;
  logic [AVG_W-1:0]  avg_r;
  logic [MUX_W-1:0]  mux_r;
  logic              start_r;
  logic              acc_r;
  logic              last_r;

  assign stat.hold      = hold_r;
  assign stat.frame_end = (sl_r == SL_W'(1));
  assign stat.avg_last  = (idx_r == CH_W'(NUM_CHANNELS - 1));

  // Single accumulator read port: sweep index during averaging, else scan position
  assign rd_addr  = cmd.avg_load ? idx_r : scan_r;
  assign rd_sum   = sums_r[rd_addr];
  assign add_sum  = rd_sum + SUM_W'(in_sample[SAMPLE_BITS-1:0]);
  assign scan_inc = (scan_r == CH_W'(NUM_CHANNELS - 1)) ? '0 : scan_r + CH_W'(1);

  // Control state next values
  always_comb begin
    scan_nxt = scan_r;
    sl_nxt   = sl_r;
    hold_nxt = hold_r;
    idx_nxt  = idx_r;
    if (cmd.acc_en) begin
      scan_nxt = scan_inc;
      sl_nxt   = stat.frame_end ? SL_W'(TOTAL_SAMPLES) : sl_r - SL_W'(1);
    end
    if (cmd.hold_clr) hold_nxt = 1'b0;
    if (cmd.avg_load) begin
      idx_nxt = stat.avg_last ? '0 : idx_r + CH_W'(1);
      if (stat.avg_last) hold_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
      sl_r   <= SL_W'(TOTAL_SAMPLES);
      hold_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      scan_r <= scan_nxt;
      sl_r   <= sl_nxt;
      hold_r <= hold_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // Accumulators: add on sample, clear as each average is read out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) sums_r[i] <= '0;
    end else if (cmd.acc_en) begin
      sums_r[scan_r] <= add_sum;
    end else if (cmd.avg_load) begin
      sums_r[idx_r] <= '0;
    end
  end

  // Result register load
  always_ff @(posedge clk) begin
    if (cmd.ctrl_load) begin
      kind_r <= KIND_CTRL;
      chan_r <= '0;
      avg_r  <= '0;
      unique case (cmd.ctrl_mode)
        CTRL_SAMPLE: begin
          mux_r   <= mux_code(CHAN_W'(scan_inc));
          start_r <= (scan_inc != '0);
          acc_r   <= 1'b1;
          last_r  <= !stat.frame_end;
        end
        CTRL_HELD: begin
          mux_r   <= mux_code(CHAN_W'(scan_r));
          start_r <= 1'b0;
          acc_r   <= 1'b0;
          last_r  <= 1'b1;
        end
        default: begin
          mux_r   <= mux_code('0);
          start_r <= 1'b1;
          acc_r   <= 1'b1;
          last_r  <= 1'b1;
        end
      endcase
    end else if (cmd.avg_load) begin
      kind_r  <= KIND_AVG;
      chan_r  <= CHAN_W'(idx_r);
      avg_r   <= AVG_W'(rd_sum >> OS_SH);
      mux_r   <= '0;
      start_r <= 1'b0;
      acc_r   <= 1'b1;
      last_r  <= stat.avg_last;
    end
  end

  assign out_kind             = kind_r;
  assign out_channel          = chan_r;
  assign out_average          = avg_r;
  assign out_mux_select       = mux_r;
  assign out_start_conversion = start_r;
  assign out_accepted         = acc_r;
  assign out_last             = last_r;

endmodule

### design/adc_scan_integrate_decimate.sv
// ADC round-robin scan with integrate-and-decimate averaging, top level.
// A conversion or tick request's control result is registered and shown the next cycle; a consume request gives none.
// A frame-ending sample then sweeps the accumulator port, one average per cycle while the output is not stalled.
// Throughput: one request per cycle, less under output stalls; no request is taken during the sweep.
// Reset: rst_n synchronous active low; resets scan position, count, hold flag and accumulators.
module adc_scan_integrate_decimate (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [asid_pkg::OP_W-1:0]     in_op,
  input  logic [asid_pkg::SMP_W-1:0]    in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [asid_pkg::CHAN_W-1:0]   out_channel,
  output logic [asid_pkg::AVG_W-1:0]    out_average,
  output logic [asid_pkg::MUX_W-1:0]    out_mux_select,
  output logic                          out_start_conversion,
  output logic                          out_accepted,
  output logic                          out_last
);
  import asid_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller
  asid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath
  asid_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_sample            (in_sample),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_kind             (out_kind),
    .out_channel          (out_channel),
    .out_average          (out_average),
    .out_mux_select       (out_mux_select),
    .out_start_conversion (out_start_conversion),
    .out_accepted         (out_accepted),
    .out_last             (out_last)
  );

endmodule
